/* rtl/rfs_pkg.sv */
// Shared types, constants and pattern lookup for the substring remover.
// No dependencies; used by rfs_cfg and remove_first_substring.
package rfs_pkg;

  localparam int NUM_PAT_REGS = 6;
  localparam int PAT_CAP      = 48;
  localparam int CFG_DW       = 64;
  localparam int CFG_AW       = 6;
  localparam int LEN_W        = 6;

  // Register indexes (byte address = 8 * index)
  localparam logic [2:0] REG_PAT0 = 3'd0;
  localparam logic [2:0] REG_LEN  = 3'd6;

  typedef logic [NUM_PAT_REGS-1:0][CFG_DW-1:0] pat_arr_t;

  typedef struct packed {
    pat_arr_t         pat;
    logic [LEN_W-1:0] len;
  } cfg_t;

  // Pick pattern character k: register k/8, byte k%8
  function automatic logic [7:0] pat_char(pat_arr_t p, logic [LEN_W-1:0] k);
    logic [7:0] c;
    c = '0;
    case (k[5:3])
      3'd0:    c = p[0][k[2:0]*8 +: 8];
      3'd1:    c = p[1][k[2:0]*8 +: 8];
      3'd2:    c = p[2][k[2:0]*8 +: 8];
      3'd3:    c = p[3][k[2:0]*8 +: 8];
      3'd4:    c = p[4][k[2:0]*8 +: 8];
      3'd5:    c = p[5][k[2:0]*8 +: 8];
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage

/* rtl/remove_first_substring.sv */
// Top level of the first-occurrence substring remover.
// Depends on rfs_pkg and rfs_cfg.
//
// Bytes of a string enter one per transfer with in_last on the final byte;
// the same string leaves with the leftmost occurrence of the configured
// pattern cut out. The most recent (length-1) bytes wait in a circular
// window memory. Work on one byte is done by a small sequencer driving a
// single byte comparator and the window memory's one read port, so the
// block takes one byte at a time: it stores or passes the byte, compares
// pattern characters against the window when it is full, shifts the
// window on a mismatch, and pops bytes out of the window when the length
// shrinks or the string ends; output stalls can hold any of these steps.
// Results
// pass through a one-entry hold stage so the final one of a string can be
// flagged with out_last; a string that yields no character gives one result
// with out_valid low. No clearing pass after reset is needed.
module remove_first_substring #(
  parameter int MAX_PATTERN = 48
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // input channel
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [7:0]                   in_byte,
  input  logic                         in_last,
  // result channel
  output logic                         out_rvalid,
  input  logic                         out_ready,
  output logic [7:0]                   out_byte,
  output logic                         out_valid,
  output logic                         out_last,
  // configuration port
  input  logic                         cfg_psel,
  input  logic                         cfg_penable,
  input  logic                         cfg_pwrite,
  input  logic [rfs_pkg::CFG_AW-1:0]   cfg_paddr,
  input  logic [rfs_pkg::CFG_DW-1:0]   cfg_pwdata,
  output logic [rfs_pkg::CFG_DW-1:0]   cfg_prdata,
  output logic                         cfg_pready
);
  import rfs_pkg::*;

  localparam int AW  = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int CAP = (MAX_PATTERN < PAT_CAP) ? MAX_PATTERN : PAT_CAP;
  localparam int LW  = $clog2(CAP + 1);
  localparam int CW  = (AW + 2 > 7) ? AW + 2 : 7;

  typedef enum logic [3:0] {
    S_IDLE, S_DRAIN, S_POP, S_MAIN, S_CMP, S_CMPB, S_FAIL, S_PUSH, S_TAIL, S_FIN
  } state_t;

  cfg_t cfg;

  rfs_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  // Window memory
  logic [7:0]    win_mem [MAX_PATTERN];
  logic [7:0]    rd_data_r;
  logic [AW-1:0] rd_addr, wr_addr;
  logic [AW-1:0] rd_off;
  logic          wr_en;

  // Sequencer state
  state_t        state_r, state_nxt, ret_r, ret_nxt;
  logic [AW-1:0] head_r, head_nxt;
  logic [AW-1:0] fill_r, fill_nxt;
  logic [AW-1:0] idx_r, idx_nxt;
  logic          removed_r, removed_nxt;
  logic [7:0]    b_r, b_nxt;
  logic          last_r, last_nxt;
  logic [LW-1:0] len_r, len_nxt;
  logic          pend_vld_r, pend_vld_nxt;
  logic [7:0]    pend_byte_r, pend_byte_nxt;
  logic          ovld_r, ovld_nxt;
  logic [7:0]    obyte_r, obyte_nxt;
  logic          ovalid_r, ovalid_nxt;
  logic          olast_r, olast_nxt;

  logic          bypass, can_load, prod_req, prod_ok;
  logic [7:0]    prod_byte;
  logic [LW-1:0] len_m1, target;

  // Circular index add, both operands below MAX_PATTERN
  function automatic logic [AW-1:0] wrap(logic [AW-1:0] a, logic [AW-1:0] b);
    logic [AW:0] s;
    s = (AW+1)'(a) + (AW+1)'(b);
    if (s >= (AW+1)'(MAX_PATTERN)) begin
      s = s - (AW+1)'(MAX_PATTERN);
    end
    return s[AW-1:0];
  endfunction

  assign bypass   = (len_r == '0) || removed_r;
  assign len_m1   = len_r - LW'(1);
  assign target   = bypass ? '0 : len_m1;
  assign can_load = !ovld_r || out_ready;
  assign prod_ok  = !pend_vld_r || can_load;
  assign rd_addr  = wrap(head_r, rd_off);
  assign wr_addr  = wrap(head_r, fill_r);
  assign in_ready = (state_r == S_IDLE);

  // Next-state logic of the sequencer
  always_comb begin
    state_nxt     = state_r;
    ret_nxt       = ret_r;
    head_nxt      = head_r;
    fill_nxt      = fill_r;
    idx_nxt       = idx_r;
    removed_nxt   = removed_r;
    b_nxt         = b_r;
    last_nxt      = last_r;
    len_nxt       = len_r;
    pend_vld_nxt  = pend_vld_r;
    pend_byte_nxt = pend_byte_r;
    ovld_nxt      = ovld_r;
    obyte_nxt     = obyte_r;
    ovalid_nxt    = ovalid_r;
    olast_nxt     = olast_r;
    prod_req      = 1'b0;
    prod_byte     = b_r;
    wr_en         = 1'b0;
    rd_off        = '0;

    // Retire the output register on a transfer
    if (ovld_r && out_ready) begin
      ovld_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          b_nxt    = in_byte;
          last_nxt = in_last;
          if (CW'(cfg.len) > CW'(CAP)) begin
            len_nxt = LW'(CAP);
          end else begin
            len_nxt = LW'(cfg.len);
          end
          state_nxt = S_DRAIN;
        end
      end
      // Shrink the window to what the current length allows
      S_DRAIN: begin
        if (CW'(fill_r) > CW'(target)) begin
          state_nxt = S_POP;
          ret_nxt   = S_DRAIN;
        end else begin
          state_nxt = S_MAIN;
        end
      end
      // Emit the oldest window byte
      S_POP: begin
        prod_req  = 1'b1;
        prod_byte = rd_data_r;
        if (prod_ok) begin
          head_nxt  = wrap(head_r, AW'(1));
          fill_nxt  = fill_r - AW'(1);
          state_nxt = ret_r;
        end
      end
      S_MAIN: begin
        if (bypass) begin
          prod_req = 1'b1;
          if (prod_ok) begin
            state_nxt = S_TAIL;
          end
        end else if (CW'(fill_r) == CW'(len_m1)) begin
          idx_nxt = '0;
          if (fill_r == '0) begin
            state_nxt = S_CMPB;
          end else begin
            state_nxt = S_CMP;
          end
        end else begin
          wr_en     = 1'b1;
          fill_nxt  = fill_r + AW'(1);
          state_nxt = S_TAIL;
        end
      end
      // Compare one window byte per cycle against the pattern
      S_CMP: begin
        if (rd_data_r != pat_char(cfg.pat, LEN_W'(idx_r))) begin
          state_nxt = S_FAIL;
        end else if (CW'(idx_r) + CW'(2) < CW'(len_r)) begin
          rd_off  = idx_r + AW'(1);
          idx_nxt = idx_r + AW'(1);
        end else begin
          state_nxt = S_CMPB;
        end
      end
      // Compare the arriving byte with the final pattern character
      S_CMPB: begin
        if (b_r == pat_char(cfg.pat, LEN_W'(len_m1))) begin
          fill_nxt    = '0;
          removed_nxt = 1'b1;
          state_nxt   = S_TAIL;
        end else begin
          state_nxt = S_FAIL;
        end
      end
      S_FAIL: begin
        if (fill_r != '0) begin
          state_nxt = S_POP;
          ret_nxt   = S_PUSH;
        end else begin
          prod_req = 1'b1;
          if (prod_ok) begin
            state_nxt = S_TAIL;
          end
        end
      end
      S_PUSH: begin
        wr_en     = 1'b1;
        fill_nxt  = fill_r + AW'(1);
        state_nxt = S_TAIL;
      end
      // Flush the window at end of string
      S_TAIL: begin
        if (last_r && fill_r != '0) begin
          state_nxt = S_POP;
          ret_nxt   = S_TAIL;
        end else begin
          state_nxt = S_FIN;
        end
      end
      // Release the held result, or the empty end marker
      S_FIN: begin
        if (pend_vld_r || last_r) begin
          if (can_load) begin
            ovld_nxt     = 1'b1;
            obyte_nxt    = pend_vld_r ? pend_byte_r : 8'd0;
            ovalid_nxt   = pend_vld_r;
            olast_nxt    = last_r;
            pend_vld_nxt = 1'b0;
            state_nxt    = S_IDLE;
          end
        end else begin
          state_nxt = S_IDLE;
        end
        if (last_r) begin
          fill_nxt    = '0;
          removed_nxt = 1'b0;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    // Hold the newest result; push the previous one to the output register
    if (prod_req && prod_ok) begin
      if (pend_vld_r) begin
        ovld_nxt   = 1'b1;
        obyte_nxt  = pend_byte_r;
        ovalid_nxt = 1'b1;
        olast_nxt  = 1'b0;
      end
      pend_vld_nxt  = 1'b1;
      pend_byte_nxt = prod_byte;
    end
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      ret_r      <= S_IDLE;
      head_r     <= '0;
      fill_r     <= '0;
      removed_r  <= 1'b0;
      pend_vld_r <= 1'b0;
      ovld_r     <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      ret_r      <= ret_nxt;
      head_r     <= head_nxt;
      fill_r     <= fill_nxt;
      removed_r  <= removed_nxt;
      pend_vld_r <= pend_vld_nxt;
      ovld_r     <= ovld_nxt;
    end
    idx_r       <= idx_nxt;
    b_r         <= b_nxt;
    last_r      <= last_nxt;
    len_r       <= len_nxt;
    pend_byte_r <= pend_byte_nxt;
    obyte_r     <= obyte_nxt;
    ovalid_r    <= ovalid_nxt;
    olast_r     <= olast_nxt;
  end

  // Window memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      win_mem[wr_addr] <= b_r;
    end
    rd_data_r <= win_mem[rd_addr];
  end

  assign out_rvalid = ovld_r;
  assign out_byte   = obyte_r;
  assign out_valid  = ovalid_r;
  assign out_last   = olast_r;

endmodule

/* rtl/rfs_cfg.sv */
// APB-style register file holding the pattern bytes and pattern length.
// Depends on rfs_pkg.
module rfs_cfg (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [rfs_pkg::CFG_AW-1:0]   paddr,
  input  logic [rfs_pkg::CFG_DW-1:0]   pwdata,
  output logic [rfs_pkg::CFG_DW-1:0]   prdata,
  output logic                         pready,
  output rfs_pkg::cfg_t                cfg
);
  import rfs_pkg::*;

  pat_arr_t         pat_r;
  logic [LEN_W-1:0] len_r;
  logic [2:0]       idx;
  logic             wr_en;

  assign idx    = paddr[5:3];
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;

  // Capture register writes on the access phase
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_r <= '0;
      len_r <= '0;
    end else if (wr_en) begin
      if (idx < 3'(NUM_PAT_REGS)) begin
        pat_r[idx] <= pwdata;
      end else if (idx == REG_LEN) begin
        len_r <= pwdata[LEN_W-1:0];
      end
    end
  end

  // Read back the addressed register
  always_comb begin
    prdata = '0;
    case (idx)
      REG_LEN: prdata = CFG_DW'(len_r);
      default: begin
        if (idx < 3'(NUM_PAT_REGS)) begin
          prdata = pat_r[idx];
        end
      end
    endcase
  end

  assign cfg.pat = pat_r;
  assign cfg.len = len_r;

endmodule

/* dv/remove_first_substring_tb.sv */
`timescale 1ns / 100ps
// Testbench for remove_first_substring: drives byte strings and APB pattern writes,
// predicts the filtered string in a scoreboard class and checks every result transfer.
// Depends on rfs_pkg and remove_first_substring.

// One expected character of the filtered string
typedef struct packed {
  logic [7:0] ch;
  logic       has_char;
  logic       fin;
} cut_char_t;

// Predicts the string with its first pattern occurrence cut out; holds what is due
class strip_board;
  localparam int WIN_DEPTH = 48;

  logic [63:0] pat_regs [rfs_pkg::NUM_PAT_REGS] = '{default: '0};
  logic [5:0]  pat_len = '0;
  logic [7:0]  held [WIN_DEPTH];
  int          held_fill = 0;
  bit          cut_done = 1'b0;
  cut_char_t   due_chars [$];
  int          errors = 0;

  function void set_reg(logic [2:0] idx, logic [63:0] v);
    if (idx == rfs_pkg::REG_LEN) pat_len = v[5:0];
    else if (idx < rfs_pkg::NUM_PAT_REGS) pat_regs[idx] = v;
  endfunction

  function logic [7:0] pat_at(int k);
    return pat_regs[k / 8][(k % 8) * 8 +: 8];
  endfunction

  function void owe(logic [7:0] ch, logic has_char);
    cut_char_t c;
    c.ch = ch;
    c.has_char = has_char;
    c.fin = 1'b0;
    due_chars.push_back(c);
  endfunction

  function logic [7:0] pop_held();
    logic [7:0] b;
    b = held[0];
    for (int i = 1; i < held_fill; i++) held[i - 1] = held[i];
    if (held_fill > 0) held_fill--;
    return b;
  endfunction

  // Advance the window with one accepted input transfer and queue what it releases
  function void take_char(logic [7:0] b, logic fin);
    int  n;
    int  start;
    bit  hit;
    n = (pat_len > WIN_DEPTH) ? WIN_DEPTH : int'(pat_len);
    start = due_chars.size();
    if (held_fill > WIN_DEPTH - 1) held_fill = WIN_DEPTH - 1;
    if (n == 0 || cut_done) begin
      while (held_fill > 0) owe(pop_held(), 1'b1);
      owe(b, 1'b1);
    end else begin
      // shrink the window if the length dropped mid-string
      while (held_fill > n - 1) owe(pop_held(), 1'b1);
      if (held_fill == n - 1) begin
        hit = (b == pat_at(n - 1));
        for (int i = 0; i < n - 1; i++)
          if (held[i] != pat_at(i)) hit = 1'b0;
        if (hit) begin
          held_fill = 0;
          cut_done = 1'b1;
        end else if (held_fill > 0) begin
          owe(pop_held(), 1'b1);
          held[held_fill] = b;
          held_fill++;
        end else begin
          owe(b, 1'b1);
        end
      end else begin
        held[held_fill] = b;
        held_fill++;
      end
    end
    // flush at end of string; an empty step yields the end marker
    if (fin) begin
      while (held_fill > 0) owe(pop_held(), 1'b1);
      if (due_chars.size() == start) owe(8'h00, 1'b0);
      due_chars[due_chars.size() - 1].fin = 1'b1;
      held_fill = 0;
      cut_done = 1'b0;
    end
  endfunction

  // Compare one accepted result transfer with the oldest expectation
  function void match_char(logic [7:0] ch, logic has_char, logic fin);
    cut_char_t want;
    if (due_chars.size() == 0) begin
      $error("unexpected result: out_byte=%0h out_valid=%0b out_last=%0b",
             ch, has_char, fin);
      errors++;
      return;
    end
    want = due_chars.pop_front();
    if (ch !== want.ch) begin
      $error("out_byte: expected %0h, got %0h", want.ch, ch);
      errors++;
    end
    if (has_char !== want.has_char) begin
      $error("out_valid: expected %0b, got %0b", want.has_char, has_char);
      errors++;
    end
    if (fin !== want.fin) begin
      $error("out_last: expected %0b, got %0b", want.fin, fin);
      errors++;
    end
  endfunction
endclass

module remove_first_substring_tb;
  import rfs_pkg::*;

  localparam int MAX_PAT      = 48;
  localparam int SETTLE_WAIT  = 200;
  localparam int HOLD_CYCLES  = 400;
  localparam int QUIET_LIMIT  = 5000;
  localparam int IDLE_PERCENT = 37;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  logic [7:0]        in_byte;
  logic              in_last;
  logic              out_rvalid;
  logic              out_ready;
  logic [7:0]        out_byte;
  logic              out_valid;
  logic              out_last;
  logic              cfg_psel;
  logic              cfg_penable;
  logic              cfg_pwrite;
  logic [CFG_AW-1:0] cfg_paddr;
  logic [CFG_DW-1:0] cfg_pwdata;
  logic [CFG_DW-1:0] cfg_prdata;
  logic              cfg_pready;

  strip_board  book;
  bit          calm = 1'b0;
  bit          hold_req = 1'b0;
  logic [7:0]  pat_copy [MAX_PAT];

  remove_first_substring #(.MAX_PATTERN(MAX_PAT)) dut (
    .clk, .rst_n,
    .in_valid, .in_ready, .in_byte, .in_last,
    .out_rvalid, .out_ready, .out_byte, .out_valid, .out_last,
    .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr, .cfg_pwdata,
    .cfg_prdata, .cfg_pready
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Setup and access phases, then psel drops so back-to-back writes never collide
  task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 3'b000};
    cfg_pwdata  <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    book.set_reg(idx, val);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // Offer one character, with random idle cycles ahead of it
  task automatic send_char(input logic [7:0] b, input logic fin);
    while (!calm && $urandom_range(99) < IDLE_PERCENT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    in_last  <= fin;
    do @(posedge clk); while (!in_ready);
    book.take_char(b, fin);
  endtask

  task automatic send_text(input string s, input bit close);
    for (int i = 0; i < s.len(); i++) send_char(s[i], close && i == s.len() - 1);
  endtask

  // Drop valid, drain every due result, then let the block finish silent work
  task automatic settle();
    in_valid <= 1'b0;
    while (book.due_chars.size() != 0) @(posedge clk);
    repeat (SETTLE_WAIT) @(posedge clk);
  endtask

  // Load a pattern (narrow: letters a..c, else any byte) and the length register
  task automatic load_pattern(input logic [5:0] len_val, input bit narrow);
    logic [63:0] w;
    for (int r = 0; r < NUM_PAT_REGS; r++) begin
      for (int k = 0; k < 8; k++) begin
        pat_copy[r * 8 + k] = narrow ? 8'(8'h61 + $urandom_range(2)) : 8'($urandom_range(255));
        w[k * 8 +: 8] = pat_copy[r * 8 + k];
      end
      write_reg(REG_PAT0 + 3'(r), w);
    end
    write_reg(REG_LEN, {58'd0, len_val});
  endtask

  // Strings mixing pattern copies (some broken), random bytes and letters a..d
  task automatic run_phase(input logic [5:0] len_val, input bit narrow, input int budget,
                           input bit may_cut);
    logic [7:0] txt [$];
    int         n;
    int         sent;
    int         slen;
    int         k;
    int         r;
    int         stop;
    bit         cut;
    settle();
    load_pattern(len_val, narrow);
    n = (len_val > MAX_PAT) ? MAX_PAT : int'(len_val);
    sent = 0;
    while (sent < budget) begin
      slen = $urandom_range(1, n * 2 + 12);
      cut = may_cut && (sent + slen >= budget) && ($urandom_range(1) == 1);
      txt.delete();
      while (txt.size() < slen) begin
        r = $urandom_range(99);
        if (n > 0 && r < 25) begin
          k = ($urandom_range(99) < 70) ? n : $urandom_range(1, n);
          for (int j = 0; j < k; j++) txt.push_back(pat_copy[j]);
        end else if (r < 40) begin
          txt.push_back(8'($urandom_range(255)));
        end else begin
          txt.push_back(8'(8'h61 + $urandom_range(3)));
        end
      end
      // keep the phase within its budget
      while (txt.size() > budget - sent) void'(txt.pop_back());
      // a cut string leaves its tail in the window for the next phase
      stop = cut ? (txt.size() + 1) / 2 : txt.size();
      for (int j = 0; j < stop; j++) send_char(txt[j], !cut && j == txt.size() - 1);
      sent += stop;
    end
  endtask

  // Result side: random stalls, one long hold-off on request
  initial begin
    forever begin
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        out_ready <= calm || ($urandom_range(99) >= IDLE_PERCENT);
        @(posedge clk);
      end
      if (out_rvalid === 1'b1 && out_ready) book.match_char(out_byte, out_valid, out_last);
    end
  end

  // End the run when no transfer happens for too long
  initial begin
    int quiet;
    quiet = 0;
    @(posedge clk iff rst_n);
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_rvalid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("remove_first_substring_tb: FAIL");
    $finish;
  end

  initial begin
    book = new();
    rst_n       <= 1'b0;
    in_valid    <= 1'b0;
    in_byte     <= 8'h00;
    in_last     <= 1'b0;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= '0;
    cfg_pwdata  <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: pattern "abc"
    load_pattern(6'd3, 1'b1);
    write_reg(REG_PAT0, 64'h0000_0000_0063_6261);
    pat_copy[0] = 8'h61;
    // zero byte alone, then a string that is exactly the pattern
    send_char(8'h00, 1'b1);
    send_text("abc", 1'b1);
    // only the first of two overlapping-prefix occurrences goes
    send_char(8'hFF, 1'b0);
    send_text("aabcabc", 1'b1);
    // shrink the length mid-string: the window spills its oldest bytes
    send_text("ab", 1'b0);
    settle();
    write_reg(REG_LEN, 64'd1);
    send_text("xa", 1'b1);
    // drop the length to zero mid-string: the whole window passes
    settle();
    write_reg(REG_LEN, 64'd3);
    send_text("ab", 1'b0);
    settle();
    write_reg(REG_LEN, 64'd0);
    send_char(8'h63, 1'b1);

    // Random phases; the first one runs against a long receiver hold-off
    settle();
    hold_req = 1'b1;
    run_phase(6'd3, 1'b1, 50, 1'b1);
    run_phase(6'd1, 1'b1, 40, 1'b1);
    run_phase(6'd0, 1'b0, 40, 1'b1);
    run_phase(6'd48, 1'b1, 70, 1'b1);
    run_phase(6'd63, 1'b1, 50, 1'b1);
    calm = 1'b1;
    run_phase(6'($urandom_range(2, 8)), 1'b1, 50, 1'b1);
    calm = 1'b0;
    run_phase(6'($urandom_range(9, 47)), 1'b0, 50, 1'b1);
    run_phase(6'($urandom_range(1, 6)), 1'b1, 50, 1'b0);

    settle();
    if (book.due_chars.size() != 0)
      $error("%0d expected results never arrived", book.due_chars.size());
    if (book.errors == 0 && book.due_chars.size() == 0) begin
      $display("remove_first_substring_tb: PASS");
    end else begin
      $display("remove_first_substring_tb: FAIL");
    end
    $finish;
  end

endmodule
